@@ rtl/bpc_pkg.sv @@
// bpc_pkg: types and constants shared by the pixel combiner pipeline
// no dependencies; imported by every module of the block

package bpc_pkg;

    localparam int PIXEL_W = 32;
    localparam int CHAN_W  = 8;
    localparam int SUM_W   = 16;
    localparam int NUM_CHAN = 3;

    localparam logic [1:0] MODE_COPY    = 2'd0;
    localparam logic [1:0] MODE_ALPHA   = 2'd1;
    localparam logic [1:0] MODE_KEY     = 2'd2;
    localparam logic [1:0] MODE_DIFFUSE = 2'd3;

    localparam logic [CHAN_W-1:0]  CHAN_MAX    = 8'hff;
    localparam logic [PIXEL_W-1:0] OPAQUE_MASK = 32'hff00_0000;

    // decoded item after the first stage
    typedef struct packed {
        logic               we;
        logic               blend;
        logic [CHAN_W-1:0]  weight;
        logic [PIXEL_W-1:0] pixel;
        logic [PIXEL_W-1:0] dst;
        logic [PIXEL_W-1:0] src;
    } dec_t;

    // weighted channel sums after the second stage
    typedef struct packed {
        logic                            we;
        logic                            blend;
        logic [PIXEL_W-1:0]              pixel;
        logic [NUM_CHAN-1:0][SUM_W-1:0]  sum;
    } mul_t;

    // finished item
    typedef struct packed {
        logic               we;
        logic [PIXEL_W-1:0] pixel;
    } res_t;

endpackage

@@ rtl/bpc_decode.sv @@
// bpc_decode: first pipeline stage, mode decode and operand selection
// depends on bpc_pkg

module bpc_decode (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  req_type,
    input  logic [bpc_pkg::PIXEL_W-1:0] source_pixel,
    input  logic [bpc_pkg::PIXEL_W-1:0] dest_pixel,
    input  logic [bpc_pkg::PIXEL_W-1:0] ref_color,
    output logic                        dec_valid,
    input  logic                        dec_ready,
    output bpc_pkg::dec_t               dec
);
    import bpc_pkg::*;

    logic  valid_reg;
    dec_t  dec_reg;
    dec_t  dec_next;

    always_comb
    begin
        dec_next        = '0;
        dec_next.dst    = dest_pixel;
        dec_next.src    = source_pixel;
        dec_next.pixel  = dest_pixel;
        dec_next.we     = 1'b0;
        dec_next.blend  = 1'b0;
        dec_next.weight = '0;
        case (req_type)
            MODE_COPY:
            begin
                dec_next.we    = 1'b1;
                dec_next.pixel = source_pixel;
            end
            MODE_ALPHA:
            begin
                if (source_pixel != '0)
                begin
                    dec_next.we = 1'b1;
                    if ((source_pixel & OPAQUE_MASK) == OPAQUE_MASK)
                    begin
                        dec_next.pixel = source_pixel;
                    end
                    else
                    begin
                        dec_next.blend  = 1'b1;
                        dec_next.weight = source_pixel[31:24];
                    end
                end
            end
            MODE_KEY:
            begin
                if (source_pixel != ref_color)
                begin
                    dec_next.we    = 1'b1;
                    dec_next.pixel = source_pixel;
                end
            end
            MODE_DIFFUSE:
            begin
                dec_next.src = ref_color;
                if (source_pixel[7:0] != '0)
                begin
                    dec_next.we = 1'b1;
                    if (source_pixel[7:0] == CHAN_MAX)
                    begin
                        dec_next.pixel = ref_color;
                    end
                    else
                    begin
                        dec_next.blend  = 1'b1;
                        dec_next.weight = source_pixel[7:0];
                    end
                end
            end
            default:
            begin
                dec_next.we = 1'b0;
            end
        endcase
    end

    assign in_ready = !valid_reg || dec_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            dec_reg <= dec_next;
        end
    end

    assign dec_valid = valid_reg;
    assign dec       = dec_reg;

endmodule

@@ rtl/bpc_weight_mul.sv @@
// bpc_weight_mul: second pipeline stage, per-channel weighted sums
// depends on bpc_pkg

module bpc_weight_mul (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          dec_valid,
    output logic          dec_ready,
    input  bpc_pkg::dec_t dec,
    output logic          mul_valid,
    input  logic          mul_ready,
    output bpc_pkg::mul_t mul
);
    import bpc_pkg::*;

    logic  valid_reg;
    mul_t  mul_reg;
    mul_t  mul_next;
    logic [CHAN_W-1:0] inv_w;

    // 255 - w is the bitwise complement of an 8-bit weight
    assign inv_w = ~dec.weight;

    always_comb
    begin
        mul_next.we    = dec.we;
        mul_next.blend = dec.blend;
        mul_next.pixel = dec.pixel;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            mul_next.sum[c] = SUM_W'(dec.dst[c*CHAN_W +: CHAN_W]) * SUM_W'(inv_w)
                            + SUM_W'(dec.src[c*CHAN_W +: CHAN_W]) * SUM_W'(dec.weight);
        end
        // destination alpha is kept on a blend
        if (dec.blend)
        begin
            mul_next.pixel = dec.dst;
        end
    end

    assign dec_ready = !valid_reg || mul_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (dec_ready)
        begin
            valid_reg <= dec_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dec_ready && dec_valid)
        begin
            mul_reg <= mul_next;
        end
    end

    assign mul_valid = valid_reg;
    assign mul       = mul_reg;

endmodule

@@ rtl/bpc_div255.sv @@
// bpc_div255: third pipeline stage, division of the channel sums by 255
// and assembly of the output pixel; depends on bpc_pkg

module bpc_div255 (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          mul_valid,
    output logic          mul_ready,
    input  bpc_pkg::mul_t mul,
    output logic          res_valid,
    input  logic          res_ready,
    output bpc_pkg::res_t res
);
    import bpc_pkg::*;

    logic  valid_reg;
    res_t  res_reg;
    res_t  res_next;
    logic [SUM_W:0] q_sum [NUM_CHAN];

    // x / 255 == (x + (x >> 8) + 1) >> 8 for every sum up to 255 * 255
    always_comb
    begin
        res_next.we    = mul.we;
        res_next.pixel = mul.pixel;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            q_sum[c] = (SUM_W+1)'(mul.sum[c]) + (SUM_W+1)'(mul.sum[c] >> CHAN_W)
                     + (SUM_W+1)'(1);
            if (mul.blend)
            begin
                res_next.pixel[c*CHAN_W +: CHAN_W] = q_sum[c][SUM_W-1:CHAN_W];
            end
        end
    end

    assign mul_ready = !valid_reg || res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (mul_ready)
        begin
            valid_reg <= mul_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_ready && mul_valid)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;

endmodule

@@ rtl/blit_pixel_combiner.sv @@
// blit_pixel_combiner: top level of the ARGB8888 pixel combiner
// depends on bpc_pkg, bpc_decode, bpc_weight_mul, bpc_div255
//
// usage:
//   an item (req_type, source_pixel, dest_pixel) is taken on in_valid and
//   in_ready; the result (write_enable, result_pixel) is offered on
//   out_valid and taken on out_ready. reference_color is loaded through
//   cfg_wr_en / cfg_wr_data and must only change while no item is in flight.
//   out_valid rises once the item has passed the decode, multiply and divide
//   registers in turn; one item per clock is sustained while out_ready is
//   high, set by the three register stages (decode, 8x8 weight multiplies,
//   divide by 255) each advancing every cycle.
//   every stage holds its own valid bit, so a stalled output lets the
//   earlier stages keep filling; in_ready drops only when all three stages
//   hold items and out_ready is low. nothing is lost or repeated on a stall.
//   reset empties the pipeline and clears reference_color to zero.

module blit_pixel_combiner (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  req_type,
    input  logic [bpc_pkg::PIXEL_W-1:0] source_pixel,
    input  logic [bpc_pkg::PIXEL_W-1:0] dest_pixel,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        write_enable,
    output logic [bpc_pkg::PIXEL_W-1:0] result_pixel,
    input  logic                        cfg_wr_en,
    input  logic [bpc_pkg::PIXEL_W-1:0] cfg_wr_data
);
    import bpc_pkg::*;

    logic [PIXEL_W-1:0] ref_color_reg;
    logic               dec_valid;
    logic               dec_ready;
    dec_t               dec;
    logic               mul_valid;
    logic               mul_ready;
    mul_t               mul;
    res_t               res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_color_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            ref_color_reg <= cfg_wr_data;
        end
    end

    bpc_decode u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .source_pixel (source_pixel),
        .dest_pixel   (dest_pixel),
        .ref_color    (ref_color_reg),
        .dec_valid    (dec_valid),
        .dec_ready    (dec_ready),
        .dec          (dec)
    );

    bpc_weight_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .dec_valid (dec_valid),
        .dec_ready (dec_ready),
        .dec       (dec),
        .mul_valid (mul_valid),
        .mul_ready (mul_ready),
        .mul       (mul)
    );

    bpc_div255 u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .mul_valid (mul_valid),
        .mul_ready (mul_ready),
        .mul       (mul),
        .res_valid (out_valid),
        .res_ready (out_ready),
        .res       (res)
    );

    assign write_enable = res.we;
    assign result_pixel = res.pixel;

endmodule

@@ rtl/bpc_checker.sv @@
// bpc_checker: port-level assertions for blit_pixel_combiner, bound below
// depends on bpc_pkg for widths

module bpc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        write_enable,
    input logic [bpc_pkg::PIXEL_W-1:0] result_pixel
);
    import bpc_pkg::*;

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("out_valid seen after reset");

    // input back-pressure only when the output holds an item and stalls
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("in_ready low with room in the pipeline");

    a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("out_valid dropped during stall");

    a_out_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(result_pixel) && $stable(write_enable)))
        else $error("result item changed during stall");

endmodule

bind blit_pixel_combiner bpc_checker u_bpc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .write_enable (write_enable),
    .result_pixel (result_pixel)
);
